// ----- hdl/lfmc_pkg.sv -----
// shared types and constants of the line follow maze controller
package lfmc_pkg;

  localparam int REG_W = 14;
  localparam int DUTY_W = 15;
  localparam int SENSOR_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_WIDTH_DEFAULT = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [REG_W-1:0] LEFT_BASE_RESET = REG_W'(5800);
  localparam logic [REG_W-1:0] RIGHT_BASE_RESET = REG_W'(6000);
  localparam logic [REG_W-1:0] TURN_BOOST_RESET = REG_W'(1000);

  localparam int MS_LOST_SPIN = 500;
  localparam int MS_CROSS_FWD = 150;
  localparam int MS_CROSS_TURN = 550;
  localparam int MS_LJ_FWD = 70;
  localparam int MS_LJ_TURN = 450;
  localparam int MS_RJ_FWD1 = 50;
  localparam int MS_RJ_FWD2 = 55;
  localparam int MS_RJ_WIDE_TURN = 550;
  localparam int MS_RJ_LINE_FWD = 50;
  localparam int MS_RJ_RIGHT_TURN = 450;

  typedef enum logic [2:0] {
    CLS_LINE,
    CLS_CROSS,
    CLS_LEFT_JCT,
    CLS_RIGHT_JCT,
    CLS_DRIFT_R,
    CLS_DRIFT_L,
    CLS_LOST,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    logic tick;
    cls_t cls;
    logic wide;
    logic line;
  } item_t;

endpackage

// ----- hdl/lfmc_front.sv -----
// front end: accepts words and classifies the sensor pattern
module lfmc_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [lfmc_pkg::SENSOR_W-1:0] sensor_byte,
  input  logic                          q_full,
  output logic                          q_push,
  output lfmc_pkg::item_t               q_item
);
  import lfmc_pkg::*;

  cls_t cls;
  logic wide;
  logic line;

  always_comb begin
    unique case (sensor_byte)
      8'h18: cls = CLS_LINE;
      8'hFF, 8'h7F, 8'hFE, 8'h7E: cls = CLS_CROSS;
      8'hF0, 8'hF8, 8'h78: cls = CLS_LEFT_JCT;
      8'h0F, 8'h1F, 8'h1E: cls = CLS_RIGHT_JCT;
      8'h08, 8'h0C: cls = CLS_DRIFT_R;
      8'h10, 8'h30: cls = CLS_DRIFT_L;
      8'h00: cls = CLS_LOST;
      default: cls = CLS_OTHER;
    endcase
  end

  assign wide = (sensor_byte == 8'hFF) || (sensor_byte == 8'h7F) || (sensor_byte == 8'h3F) ||
                (sensor_byte == 8'hFE) || (sensor_byte == 8'hFC) || (sensor_byte == 8'h7E) ||
                (sensor_byte == 8'h7C) || (sensor_byte == 8'h3E);
  assign line = (sensor_byte == 8'h18) || (sensor_byte == 8'h08) || (sensor_byte == 8'h04) ||
                (sensor_byte == 8'h0C) || (sensor_byte == 8'h10) || (sensor_byte == 8'h20) ||
                (sensor_byte == 8'h30);

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_item.tick = op;
    q_item.cls = cls;
    q_item.wide = wide;
    q_item.line = line;
  end
endmodule

// ----- hdl/lfmc_queue.sv -----
// short queue of classified words between front and back
module lfmc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lfmc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lfmc_pkg::item_t head
);
  import lfmc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  item_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- hdl/lfmc_back.sv -----
// back end: drive state machine, settings and result register
module lfmc_back #(
  parameter int COUNT_WIDTH = lfmc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lfmc_pkg::REG_W-1:0]       cfg_data,
  input  logic                             q_not_empty,
  input  lfmc_pkg::item_t                  q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       motor_cmd,
  output logic [lfmc_pkg::DUTY_W-1:0]      left_duty,
  output logic [lfmc_pkg::DUTY_W-1:0]      right_duty,
  output logic [2:0]                       leds,
  output logic                             busy_res
);
  import lfmc_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WAIT_CROSS,
    PH_READ_CROSS,
    PH_WAIT_LJ,
    PH_READ_LJ,
    PH_WAIT_RJ1,
    PH_READ_RJ1,
    PH_WAIT_RJ2,
    PH_READ_RJ2,
    PH_TURN,
    PH_TURN_CLR
  } phase_t;

  typedef enum logic [1:0] {
    CMD_STOP,
    CMD_FWD,
    CMD_LEFT,
    CMD_RIGHT
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEFT_BASE,
    REG_RIGHT_BASE,
    REG_TURN_BOOST,
    REG_UNUSED
  } reg_idx_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_LOST = COUNT_WIDTH'(MS_LOST_SPIN);
  localparam logic [COUNT_WIDTH-1:0] CNT_CROSS_FWD = COUNT_WIDTH'(MS_CROSS_FWD);
  localparam logic [COUNT_WIDTH-1:0] CNT_CROSS_TURN = COUNT_WIDTH'(MS_CROSS_TURN);
  localparam logic [COUNT_WIDTH-1:0] CNT_LJ_FWD = COUNT_WIDTH'(MS_LJ_FWD);
  localparam logic [COUNT_WIDTH-1:0] CNT_LJ_TURN = COUNT_WIDTH'(MS_LJ_TURN);
  localparam logic [COUNT_WIDTH-1:0] CNT_RJ_FWD1 = COUNT_WIDTH'(MS_RJ_FWD1);
  localparam logic [COUNT_WIDTH-1:0] CNT_RJ_FWD2 = COUNT_WIDTH'(MS_RJ_FWD2);
  localparam logic [COUNT_WIDTH-1:0] CNT_RJ_WIDE = COUNT_WIDTH'(MS_RJ_WIDE_TURN);
  localparam logic [COUNT_WIDTH-1:0] CNT_RJ_LINE = COUNT_WIDTH'(MS_RJ_LINE_FWD);
  localparam logic [COUNT_WIDTH-1:0] CNT_RJ_RIGHT = COUNT_WIDTH'(MS_RJ_RIGHT_TURN);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [REG_W-1:0] left_base;
  logic [REG_W-1:0] right_base;
  logic [REG_W-1:0] turn_boost;

  phase_t phase, phase_next;
  logic [COUNT_WIDTH-1:0] countdown, countdown_next;
  cmd_t drive_cmd, drive_cmd_next;
  logic [DUTY_W-1:0] left_drive, left_drive_next;
  logic [DUTY_W-1:0] right_drive, right_drive_next;
  logic [2:0] led_bits, led_bits_next;
  logic out_valid_next;

  logic [DUTY_W-1:0] left_plain, right_plain, left_boosted, right_boosted;
  phase_t tick_phase;
  logic timed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_base <= LEFT_BASE_RESET;
      right_base <= RIGHT_BASE_RESET;
      turn_boost <= TURN_BOOST_RESET;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT_BASE: left_base <= cfg_data;
        REG_RIGHT_BASE: right_base <= cfg_data;
        REG_TURN_BOOST: turn_boost <= cfg_data;
        default: ;
      endcase
    end
  end

  assign left_plain = DUTY_W'(left_base);
  assign right_plain = DUTY_W'(right_base);
  assign left_boosted = DUTY_W'(left_base) + DUTY_W'(turn_boost);
  assign right_boosted = DUTY_W'(right_base) + DUTY_W'(turn_boost);

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    unique case (phase)
      PH_WAIT_CROSS: begin tick_phase = PH_READ_CROSS; timed = 1'b1; end
      PH_WAIT_LJ: begin tick_phase = PH_READ_LJ; timed = 1'b1; end
      PH_WAIT_RJ1: begin tick_phase = PH_READ_RJ1; timed = 1'b1; end
      PH_WAIT_RJ2: begin tick_phase = PH_READ_RJ2; timed = 1'b1; end
      PH_TURN, PH_TURN_CLR: begin tick_phase = PH_IDLE; timed = 1'b1; end
      default: begin tick_phase = phase; timed = 1'b0; end
    endcase
  end

  always_comb begin
    phase_next = phase;
    countdown_next = countdown;
    drive_cmd_next = drive_cmd;
    left_drive_next = left_drive;
    right_drive_next = right_drive;
    led_bits_next = led_bits;
    out_valid_next = out_valid && !out_ready;
    if (q_pop) begin
      out_valid_next = 1'b1;
      if (q_head.tick) begin
        if (timed) begin
          if (countdown > CNT_ONE) begin
            countdown_next = countdown - 1'b1;
          end else begin
            countdown_next = '0;
            if (phase == PH_TURN_CLR) begin
              led_bits_next = 3'd0;
            end
            phase_next = tick_phase;
          end
        end
      end else begin
        unique case (phase)
          PH_READ_CROSS: begin
            drive_cmd_next = CMD_LEFT;
            left_drive_next = left_plain;
            right_drive_next = right_boosted;
            phase_next = PH_TURN;
            countdown_next = CNT_CROSS_TURN;
          end
          PH_READ_LJ: begin
            drive_cmd_next = CMD_LEFT;
            left_drive_next = left_plain;
            right_drive_next = right_boosted;
            phase_next = PH_TURN;
            countdown_next = CNT_LJ_TURN;
          end
          PH_READ_RJ1: begin
            left_drive_next = left_plain;
            right_drive_next = right_plain;
            if (q_head.wide) begin
              led_bits_next = 3'd4;
              drive_cmd_next = CMD_LEFT;
              phase_next = PH_TURN;
              countdown_next = CNT_RJ_WIDE;
            end else begin
              drive_cmd_next = CMD_FWD;
              phase_next = PH_WAIT_RJ2;
              countdown_next = CNT_RJ_FWD2;
            end
          end
          PH_READ_RJ2: begin
            phase_next = PH_TURN_CLR;
            right_drive_next = right_plain;
            if (q_head.line) begin
              led_bits_next = 3'd2;
              drive_cmd_next = CMD_FWD;
              left_drive_next = left_plain;
              countdown_next = CNT_RJ_LINE;
            end else begin
              led_bits_next = 3'd3;
              drive_cmd_next = CMD_RIGHT;
              left_drive_next = left_boosted;
              countdown_next = CNT_RJ_RIGHT;
            end
          end
          PH_WAIT_CROSS, PH_WAIT_LJ, PH_WAIT_RJ1, PH_WAIT_RJ2, PH_TURN, PH_TURN_CLR: ;
          default: begin
            left_drive_next = left_plain;
            right_drive_next = right_plain;
            unique case (q_head.cls)
              CLS_LINE: drive_cmd_next = CMD_FWD;
              CLS_CROSS: begin
                led_bits_next = 3'd1;
                drive_cmd_next = CMD_FWD;
                phase_next = PH_WAIT_CROSS;
                countdown_next = CNT_CROSS_FWD;
              end
              CLS_LEFT_JCT: begin
                drive_cmd_next = CMD_FWD;
                phase_next = PH_WAIT_LJ;
                countdown_next = CNT_LJ_FWD;
              end
              CLS_RIGHT_JCT: begin
                drive_cmd_next = CMD_FWD;
                phase_next = PH_WAIT_RJ1;
                countdown_next = CNT_RJ_FWD1;
              end
              CLS_DRIFT_R: begin
                led_bits_next = 3'd7;
                drive_cmd_next = CMD_RIGHT;
              end
              CLS_DRIFT_L: begin
                led_bits_next = 3'd7;
                drive_cmd_next = CMD_LEFT;
              end
              CLS_LOST: begin
                drive_cmd_next = CMD_LEFT;
                phase_next = PH_TURN;
                countdown_next = CNT_LOST;
              end
              default: begin
                drive_cmd_next = CMD_STOP;
                left_drive_next = '0;
                right_drive_next = '0;
              end
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      countdown <= '0;
      drive_cmd <= CMD_STOP;
      left_drive <= '0;
      right_drive <= '0;
      led_bits <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      countdown <= countdown_next;
      drive_cmd <= drive_cmd_next;
      left_drive <= left_drive_next;
      right_drive <= right_drive_next;
      led_bits <= led_bits_next;
      out_valid <= out_valid_next;
    end
  end

  assign motor_cmd = drive_cmd;
  assign left_duty = left_drive;
  assign right_duty = right_drive;
  assign leds = led_bits;
  assign busy_res = (phase != PH_IDLE);
endmodule

// ----- hdl/line_follow_maze_controller.sv -----
// top level of the line follow maze controller
//
//   channel  handshake             word
//   in       in_valid/in_ready     op, sensor_byte
//   out      out_valid/out_ready   motor_cmd, left_duty, right_duty, leds, busy_res
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one word per cycle in and out while the output is not stalled; a word is written
// into the two-entry queue and its result is registered by the single drive state register stage
// reset clears the queue, the drive state and loads the duty defaults
// a stalled output holds the state; the queue keeps accepting until full
module line_follow_maze_controller #(
  parameter int COUNT_WIDTH = lfmc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [lfmc_pkg::SENSOR_W-1:0]    sensor_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       motor_cmd,
  output logic [lfmc_pkg::DUTY_W-1:0]      left_duty,
  output logic [lfmc_pkg::DUTY_W-1:0]      right_duty,
  output logic [2:0]                       leds,
  output logic                             busy_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lfmc_pkg::REG_W-1:0]       cfg_data
);
  import lfmc_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  item_t q_item;
  item_t q_head;

  lfmc_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .sensor_byte (sensor_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  lfmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lfmc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .motor_cmd   (motor_cmd),
    .left_duty   (left_duty),
    .right_duty  (right_duty),
    .leds        (leds),
    .busy_res    (busy_res)
  );
endmodule

// ----- dv/tb.sv -----
// testbench for line_follow_maze_controller: random and directed sensor and tick traffic
`timescale 1ns / 1ps

module tb;

  localparam int REG_W = lfmc_pkg::REG_W;
  localparam int DUTY_W = lfmc_pkg::DUTY_W;
  localparam int COUNT_W = lfmc_pkg::COUNT_WIDTH_DEFAULT;
  localparam int ITEM_GOAL = 1900;
  localparam int NUM_SETTINGS = 6;
  localparam int NUM_PATHS = 6;
  localparam int TAIL_CYCLES = 8;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT_CROSS, PH_READ_CROSS, PH_WAIT_LJ, PH_READ_LJ, PH_WAIT_RJ1,
    PH_READ_RJ1, PH_WAIT_RJ2, PH_READ_RJ2, PH_TURN, PH_TURN_CLR
  } maze_phase_t;

  typedef enum logic [1:0] {CMD_STOP, CMD_FWD, CMD_LEFT, CMD_RIGHT} motor_t;
  typedef enum logic {OP_SAMPLE, OP_TICK} op_t;
  typedef enum logic [1:0] {REG_LEFT_BASE, REG_RIGHT_BASE, REG_TURN_BOOST, REG_UNUSED} reg_t;
  typedef enum int {
    PATH_CROSS, PATH_LEFT_JCT, PATH_RJ_WIDE, PATH_RJ_LINE, PATH_RJ_RIGHT, PATH_LOST
  } path_t;

  localparam logic [2:0] LED_OFF = 3'd0;
  localparam logic [2:0] LED_CROSS = 3'd1;
  localparam logic [2:0] LED_LINE = 3'd2;
  localparam logic [2:0] LED_RIGHT = 3'd3;
  localparam logic [2:0] LED_WIDE = 3'd4;
  localparam logic [2:0] LED_DRIFT = 3'd7;

  localparam logic [7:0] CROSS_SET [4] = '{8'hFF, 8'h7F, 8'hFE, 8'h7E};
  localparam logic [7:0] LJ_SET [3] = '{8'hF0, 8'hF8, 8'h78};
  localparam logic [7:0] RJ_SET [3] = '{8'h0F, 8'h1F, 8'h1E};
  localparam logic [7:0] WIDE_SET [8] = '{8'hFF, 8'h7F, 8'h3F, 8'hFE, 8'hFC, 8'h7E, 8'h7C,
                                          8'h3E};
  localparam logic [7:0] LINE_SET [7] = '{8'h18, 8'h08, 8'h04, 8'h0C, 8'h10, 8'h20, 8'h30};

  typedef struct packed {
    motor_t cmd;
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
    logic [2:0] leds;
    logic busy;
  } drive_word_t;

  class drive_scoreboard;
    logic [REG_W-1:0] left_base, right_base, boost;
    maze_phase_t phase;
    logic [COUNT_W-1:0] countdown;
    motor_t cmd;
    logic [DUTY_W-1:0] left_drv, right_drv;
    logic [2:0] led_bits;
    drive_word_t expected_drive[$];
    int errors;
    int checked;
    int path_hits[NUM_PATHS];

    function new();
      left_base = lfmc_pkg::LEFT_BASE_RESET;
      right_base = lfmc_pkg::RIGHT_BASE_RESET;
      boost = lfmc_pkg::TURN_BOOST_RESET;
      phase = PH_IDLE;
      countdown = '0;
      cmd = CMD_STOP;
      left_drv = '0;
      right_drv = '0;
      led_bits = LED_OFF;
      errors = 0;
      checked = 0;
      foreach (path_hits[i]) path_hits[i] = 0;
    endfunction

    function void write_reg(reg_t idx, logic [REG_W-1:0] val);
      case (idx)
        REG_LEFT_BASE: left_base = val;
        REG_RIGHT_BASE: right_base = val;
        REG_TURN_BOOST: boost = val;
        default: ;
      endcase
    endfunction

    function bit is_wide(logic [7:0] s);
      case (s)
        8'hFF, 8'h7F, 8'h3F, 8'hFE, 8'hFC, 8'h7E, 8'h7C, 8'h3E: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit is_line(logic [7:0] s);
      case (s)
        8'h18, 8'h08, 8'h04, 8'h0C, 8'h10, 8'h20, 8'h30: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    // waiting out a forward run or a turn
    function bit timing();
      case (phase)
        PH_WAIT_CROSS, PH_WAIT_LJ, PH_WAIT_RJ1, PH_WAIT_RJ2, PH_TURN, PH_TURN_CLR: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit ignores(op_t o);
      return (o == OP_SAMPLE) ? timing() : !timing();
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    function void set_drive(motor_t c, logic [DUTY_W-1:0] l, logic [DUTY_W-1:0] r);
      cmd = c;
      left_drv = l;
      right_drv = r;
    endfunction

    function void start_delay(maze_phase_t p, int ms);
      phase = p;
      countdown = COUNT_W'(ms);
    endfunction

    function void classify(logic [7:0] s);
      logic [DUTY_W-1:0] l, r;
      l = DUTY_W'(left_base);
      r = DUTY_W'(right_base);
      case (s)
        8'h18: set_drive(CMD_FWD, l, r);
        8'hFF, 8'h7F, 8'hFE, 8'h7E: begin
          led_bits = LED_CROSS;
          set_drive(CMD_FWD, l, r);
          start_delay(PH_WAIT_CROSS, lfmc_pkg::MS_CROSS_FWD);
        end
        8'hF0, 8'hF8, 8'h78: begin
          set_drive(CMD_FWD, l, r);
          start_delay(PH_WAIT_LJ, lfmc_pkg::MS_LJ_FWD);
        end
        8'h0F, 8'h1F, 8'h1E: begin
          set_drive(CMD_FWD, l, r);
          start_delay(PH_WAIT_RJ1, lfmc_pkg::MS_RJ_FWD1);
        end
        8'h08, 8'h0C: begin
          led_bits = LED_DRIFT;
          set_drive(CMD_RIGHT, l, r);
        end
        8'h10, 8'h30: begin
          led_bits = LED_DRIFT;
          set_drive(CMD_LEFT, l, r);
        end
        8'h00: begin
          set_drive(CMD_LEFT, l, r);
          start_delay(PH_TURN, lfmc_pkg::MS_LOST_SPIN);
          path_hits[PATH_LOST]++;
        end
        default: set_drive(CMD_STOP, '0, '0);
      endcase
    endfunction

    function void on_sample(logic [7:0] s);
      logic [DUTY_W-1:0] l, r;
      l = DUTY_W'(left_base);
      r = DUTY_W'(right_base);
      case (phase)
        PH_READ_CROSS: begin
          set_drive(CMD_LEFT, l, r + DUTY_W'(boost));
          start_delay(PH_TURN, lfmc_pkg::MS_CROSS_TURN);
          path_hits[PATH_CROSS]++;
        end
        PH_READ_LJ: begin
          set_drive(CMD_LEFT, l, r + DUTY_W'(boost));
          start_delay(PH_TURN, lfmc_pkg::MS_LJ_TURN);
          path_hits[PATH_LEFT_JCT]++;
        end
        PH_READ_RJ1: begin
          if (is_wide(s)) begin
            led_bits = LED_WIDE;
            set_drive(CMD_LEFT, l, r);
            start_delay(PH_TURN, lfmc_pkg::MS_RJ_WIDE_TURN);
            path_hits[PATH_RJ_WIDE]++;
          end else begin
            set_drive(CMD_FWD, l, r);
            start_delay(PH_WAIT_RJ2, lfmc_pkg::MS_RJ_FWD2);
          end
        end
        PH_READ_RJ2: begin
          if (is_line(s)) begin
            led_bits = LED_LINE;
            set_drive(CMD_FWD, l, r);
            start_delay(PH_TURN_CLR, lfmc_pkg::MS_RJ_LINE_FWD);
            path_hits[PATH_RJ_LINE]++;
          end else begin
            led_bits = LED_RIGHT;
            set_drive(CMD_RIGHT, l + DUTY_W'(boost), r);
            start_delay(PH_TURN_CLR, lfmc_pkg::MS_RJ_RIGHT_TURN);
            path_hits[PATH_RJ_RIGHT]++;
          end
        end
        PH_WAIT_CROSS, PH_WAIT_LJ, PH_WAIT_RJ1, PH_WAIT_RJ2, PH_TURN, PH_TURN_CLR: ;
        default: classify(s);
      endcase
    endfunction

    function void on_tick();
      maze_phase_t nxt;
      case (phase)
        PH_WAIT_CROSS: nxt = PH_READ_CROSS;
        PH_WAIT_LJ: nxt = PH_READ_LJ;
        PH_WAIT_RJ1: nxt = PH_READ_RJ1;
        PH_WAIT_RJ2: nxt = PH_READ_RJ2;
        PH_TURN, PH_TURN_CLR: nxt = PH_IDLE;
        default: return;
      endcase
      if (countdown > 1) begin
        countdown--;
        return;
      end
      countdown = '0;
      if (phase == PH_TURN_CLR) led_bits = LED_OFF;
      phase = nxt;
    endfunction

    function void note_word(op_t o, logic [7:0] s);
      drive_word_t w;
      if (o == OP_SAMPLE) on_sample(s);
      else on_tick();
      w.cmd = cmd;
      w.left = left_drv;
      w.right = right_drv;
      w.leds = led_bits;
      w.busy = busy();
      expected_drive.push_back(w);
    endfunction

    function void check_word(logic [1:0] c, logic [DUTY_W-1:0] l, logic [DUTY_W-1:0] r,
                             logic [2:0] ld, logic b);
      drive_word_t w;
      if (expected_drive.size() == 0) begin
        $error("drive word arrived with nothing expected");
        errors++;
        return;
      end
      w = expected_drive.pop_front();
      checked++;
      if (c !== w.cmd) begin
        $error("motor_cmd expected %0d got %0d", w.cmd, c);
        errors++;
      end
      if (l !== w.left) begin
        $error("left_duty expected %0d got %0d", w.left, l);
        errors++;
      end
      if (r !== w.right) begin
        $error("right_duty expected %0d got %0d", w.right, r);
        errors++;
      end
      if (ld !== w.leds) begin
        $error("leds expected %0d got %0d", w.leds, ld);
        errors++;
      end
      if (b !== w.busy) begin
        $error("busy_res expected %0d got %0d", w.busy, b);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [lfmc_pkg::SENSOR_W-1:0] sensor_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] motor_cmd;
  logic [DUTY_W-1:0] left_duty;
  logic [DUTY_W-1:0] right_duty;
  logic [2:0] leds;
  logic busy_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfmc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  drive_scoreboard tracker;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int n_counted = 0;
  int n_samples = 0;
  int n_ticks = 0;
  int n_writes = 0;

  line_follow_maze_controller DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int items_sent();
    return n_samples + n_ticks;
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      if (stall_left == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_word(motor_cmd, left_duty, right_duty, leds, busy_res);
  end

  task automatic send_word(op_t o, logic [7:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    sensor_byte <= s;
    do @(posedge clk); while (!in_ready);
    if (!tracker.ignores(o)) n_counted++;
    if (o == OP_TICK) n_ticks++;
    else n_samples++;
    tracker.note_word(o, s);
  endtask

  task automatic run_delay(bit noisy);
    while (tracker.timing()) begin
      if (noisy && $urandom_range(0, 99) < 6) send_word(OP_SAMPLE, 8'($urandom));
      else send_word(OP_TICK, 8'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_read();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 45 && r < 60) return 8'($urandom);
    case (tracker.phase)
      PH_READ_RJ1: return (r < 45) ? WIDE_SET[$urandom_range(0, 7)]
                                   : LINE_SET[$urandom_range(0, 6)];
      PH_READ_RJ2: return (r < 45) ? LINE_SET[$urandom_range(0, 6)]
                                   : WIDE_SET[$urandom_range(0, 7)];
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic finish_manoeuvre();
    while (tracker.busy()) begin
      if (tracker.timing()) run_delay(1'b1);
      else begin
        if ($urandom_range(0, 9) == 0) send_word(OP_TICK, 8'($urandom));
        send_word(OP_SAMPLE, pick_read());
      end
    end
  endtask

  task automatic run_episode();
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
    if (r < 45) send_word(OP_SAMPLE, LINE_SET[$urandom_range(0, 6)]);
    else if (r < 55) send_word(OP_TICK, 8'($urandom));
    else if (r < 88) send_word(OP_SAMPLE, 8'($urandom));
    else if (r < 90) send_word(OP_SAMPLE, CROSS_SET[$urandom_range(0, 3)]);
    else if (r < 92) send_word(OP_SAMPLE, LJ_SET[$urandom_range(0, 2)]);
    else if (r < 97) send_word(OP_SAMPLE, RJ_SET[$urandom_range(0, 2)]);
    else send_word(OP_SAMPLE, 8'h00);
    finish_manoeuvre();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_reg(reg_t idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    n_writes++;
  endtask

  task automatic apply_setting(logic [REG_W-1:0] l, logic [REG_W-1:0] r, logic [REG_W-1:0] b);
    load_reg(REG_LEFT_BASE, l);
    load_reg(REG_UNUSED, REG_W'($urandom));
    load_reg(REG_RIGHT_BASE, r);
    load_reg(REG_TURN_BOOST, b);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_run();
    send_word(OP_TICK, 8'h00);
    send_word(OP_SAMPLE, 8'h18);
    send_word(OP_SAMPLE, 8'h08);
    send_word(OP_SAMPLE, 8'h0C);
    send_word(OP_SAMPLE, 8'h10);
    send_word(OP_SAMPLE, 8'h30);
    send_word(OP_SAMPLE, 8'hA5);
    // cross with an ignored sample mid-run and an ignored tick at the read
    send_word(OP_SAMPLE, 8'hFF);
    send_word(OP_SAMPLE, 8'h18);
    run_delay(1'b0);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_SAMPLE, 8'h00);
    run_delay(1'b0);
    send_word(OP_SAMPLE, 8'h5A);
    run_delay(1'b0);
    send_word(OP_SAMPLE, 8'h1E);
    run_delay(1'b0);
    send_word(OP_SAMPLE, 8'h00);
    run_delay(1'b0);
    send_word(OP_SAMPLE, 8'h04);
    run_delay(1'b0);
  endtask

  initial begin
    int p;
    int target;
    int share;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_run();
    p = 0;
    share = (ITEM_GOAL - items_sent()) / NUM_SETTINGS;
    if (share < 1) share = 1;
    while (items_sent() < ITEM_GOAL) begin
      drain();
      case (p % NUM_SETTINGS)
        0: apply_setting('0, '0, '0);
        1: apply_setting('1, '1, '1);
        2: apply_setting(REG_W'(15000), REG_W'(15000), REG_W'(15000));
        3: apply_setting(REG_W'($urandom_range(0, 15000)), REG_W'($urandom_range(0, 15000)),
                         REG_W'($urandom_range(0, 15000)));
        4: apply_setting(lfmc_pkg::LEFT_BASE_RESET, lfmc_pkg::RIGHT_BASE_RESET,
                         lfmc_pkg::TURN_BOOST_RESET);
        default: apply_setting(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      target = items_sent() + share;
      while (items_sent() < target && items_sent() < ITEM_GOAL) run_episode();
      p++;
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d samples, %0d ticks (%0d acted on), %0d drive words checked, %0d writes",
             n_samples, n_ticks, n_counted, tracker.checked, n_writes);
    $display("turns: cross %0d, left junction %0d, right junction wide/line/right %0d/%0d/%0d",
             tracker.path_hits[PATH_CROSS], tracker.path_hits[PATH_LEFT_JCT],
             tracker.path_hits[PATH_RJ_WIDE], tracker.path_hits[PATH_RJ_LINE],
             tracker.path_hits[PATH_RJ_RIGHT]);
    $display("lost line spins %0d", tracker.path_hits[PATH_LOST]);
    if (tracker.errors == 0 && tracker.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
